### hw/rtl/binary_max_heap_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Heap queue assertion macros
// Concurrent assertion helpers shared by the heap queue RTL files.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define BMHQ_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("heap queue assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("heap queue assertion failed");

`else

`define BMHQ_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

### hw/rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// Heap queue package
// Command and status codes, datapath operations and controller links.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmhq_pkg;

	localparam int KEY_W     = 32;
	localparam int INDEX_W   = 6;
	localparam int COUNT_W   = 7;
	localparam int COMMAND_W = 2;
	localparam int STATUS_W  = 3;

	// Value reported when a command returns no key.
	localparam logic signed [KEY_W-1:0] INT_MIN = {1'b1, {(KEY_W-1){1'b0}}};

	typedef enum logic [COMMAND_W-1:0] {
		CMD_INSERT   = 2'd0,
		CMD_EXTRACT  = 2'd1,
		CMD_INCREASE = 2'd2,
		CMD_DELETE   = 2'd3
	} cmd_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_FULL       = 3'd1,
		ST_EMPTY      = 3'd2,
		ST_BAD_INDEX  = 3'd3,
		ST_NOT_LARGER = 3'd4
	} status_e;

	// Operations the controller asks of the datapath, one per cycle.
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_INS_INIT,
		DP_EX_RD,
		DP_EX_LD,
		DP_INC_RD,
		DP_INC_INIT,
		DP_DEL_RD,
		DP_DEL_DROP,
		DP_DEL_LD,
		DP_UP_RD,
		DP_UP_MOVE,
		DP_UP_PLACE,
		DP_DN_RD,
		DP_DN_MOVE,
		DP_DN_PLACE
	} dp_op_e;

	typedef struct packed {
		dp_op_e  op;
		logic    res_load;
		status_e res_status;
	} dp_cmd_t;

	typedef struct packed {
		cmd_e cmd;
		logic full;
		logic empty;
		logic idx_bad;
		logic idx_last;
		logic pos_root;
		logic up_swap;
		logic not_larger;
		logic dn_move;
	} dp_sts_t;

endpackage

### hw/rtl/bmhq_req_if.sv
// ----------------------------------------------------------------------------
// Heap queue request channel
// Valid/ready channel carrying one command item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bmhq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [31:0] value;
	logic [5:0]         index;

	modport source (output valid, output command, output value, output index, input ready);
	modport sink (input valid, input command, input value, input index, output ready);
endinterface

### hw/rtl/bmhq_rsp_if.sv
// ----------------------------------------------------------------------------
// Heap queue response channel
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bmhq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic [2:0]         status;
	logic [6:0]         count;

	modport source (output valid, output result_value, output status, output count, input ready);
	modport sink (input valid, input result_value, input status, input count, output ready);
endinterface

### hw/rtl/bmhq_dp.sv
// ----------------------------------------------------------------------------
// Heap queue datapath
// Heap store, entry count, sift position and moving key, output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_max_heap_queue_top_assert.svh"

module bmhq_dp
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [COMMAND_W-1:0]     req_command,
	input  logic signed [KEY_W-1:0]  req_value,
	input  logic [INDEX_W-1:0]       req_index,
	input  dp_cmd_t                  cmd,
	output dp_sts_t                  sts,
	output logic signed [KEY_W-1:0]  rsp_value,
	output logic [STATUS_W-1:0]      rsp_status,
	output logic [COUNT_W-1:0]       rsp_count
);

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int LW   = AW + 2;
	localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

	// Latched request.
	cmd_e                    cmd_q;
	logic signed [KEY_W-1:0] val_q;
	logic [INDEX_W-1:0]      idx_q;

	// Heap state and sift registers.
	logic [CW-1:0]           cnt_q;
	logic [AW-1:0]           pos_q;
	logic signed [KEY_W-1:0] v_q;
	logic signed [KEY_W-1:0] res_q;

	// Heap store with two registered read ports and one write port.
	logic signed [KEY_W-1:0] mem [CAPACITY];
	logic signed [KEY_W-1:0] rd_a_q;
	logic signed [KEY_W-1:0] rd_b_q;
	logic [AW-1:0]           rd_a_addr;
	logic [AW-1:0]           rd_b_addr;
	logic                    rd_en;
	logic                    wr_en;
	logic signed [KEY_W-1:0] wr_data;

	// Output registers.
	logic signed [KEY_W-1:0] out_value_q;
	status_e                 out_status_q;
	logic [COUNT_W-1:0]      out_count_q;

	// Derived positions and comparisons.
	logic [CW-1:0]           cnt_dec;
	logic [CMPW-1:0]         idx_ext;
	logic [AW-1:0]           parent;
	logic [LW-1:0]           left;
	logic [LW-1:0]           right;
	logic                    left_win;
	logic                    right_win;
	logic [LW-1:0]           best_idx;
	logic signed [KEY_W-1:0] best_val;

	assign cnt_dec = cnt_q - CW'(1);
	assign idx_ext = CMPW'(idx_q);
	assign parent  = (pos_q - AW'(1)) >> 1;
	assign left    = {1'b0, pos_q, 1'b1};
	assign right   = left + LW'(1);

	// Child selection for a sift-down step: the larger child that beats the key.
	always_comb begin
		left_win  = (left < LW'(cnt_q)) && (rd_a_q > v_q);
		right_win = (right < LW'(cnt_q)) && (rd_b_q > (left_win ? rd_a_q : v_q));
		if (right_win) begin
			best_idx = right;
			best_val = rd_b_q;
		end else begin
			best_idx = left;
			best_val = rd_a_q;
		end
	end

	// Status back to the controller.
	always_comb begin
		sts.cmd        = cmd_q;
		sts.full       = (cnt_q == CW'(CAPACITY));
		sts.empty      = (cnt_q == '0);
		sts.idx_bad    = (idx_ext >= CMPW'(cnt_q));
		sts.idx_last   = (idx_ext == CMPW'(cnt_dec));
		sts.pos_root   = (pos_q == '0);
		sts.up_swap    = (v_q > rd_a_q);
		sts.not_larger = (rd_a_q >= val_q);
		sts.dn_move    = left_win || right_win;
	end

	// Read addresses and enables per operation.
	always_comb begin
		rd_a_addr = '0;
		rd_b_addr = '0;
		rd_en     = 1'b1;
		case (cmd.op)
			DP_EX_RD: begin
				rd_b_addr = cnt_dec[AW-1:0];
			end
			DP_INC_RD: begin
				rd_a_addr = idx_ext[AW-1:0];
			end
			DP_DEL_RD: begin
				rd_a_addr = cnt_dec[AW-1:0];
			end
			DP_UP_RD: begin
				rd_a_addr = parent;
			end
			DP_DN_RD: begin
				rd_a_addr = left[AW-1:0];
				rd_b_addr = right[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// The store is written only at the current sift position.
	assign wr_en = cmd.op inside {DP_UP_MOVE, DP_UP_PLACE, DP_DN_MOVE, DP_DN_PLACE};

	always_comb begin
		case (cmd.op)
			DP_UP_MOVE: wr_data = rd_a_q;
			DP_DN_MOVE: wr_data = best_val;
			default:    wr_data = v_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_a_addr];
			rd_b_q <= mem[rd_b_addr];
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.op)
				DP_INS_INIT: cnt_q <= cnt_q + CW'(1);
				DP_EX_RD, DP_DEL_RD, DP_DEL_DROP: cnt_q <= cnt_dec;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Request latch, sift position, moving key and extracted value.
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				cmd_q <= cmd_e'(req_command);
				val_q <= req_value;
				idx_q <= req_index;
				res_q <= INT_MIN;
			end
			DP_INS_INIT: begin
				v_q   <= val_q;
				pos_q <= cnt_q[AW-1:0];
			end
			DP_EX_LD: begin
				res_q <= rd_a_q;
				v_q   <= rd_b_q;
				pos_q <= '0;
			end
			DP_INC_INIT: begin
				v_q   <= val_q;
				pos_q <= idx_ext[AW-1:0];
			end
			DP_DEL_LD: begin
				v_q   <= rd_a_q;
				pos_q <= idx_ext[AW-1:0];
			end
			DP_UP_MOVE: begin
				pos_q <= parent;
			end
			DP_DN_MOVE: begin
				pos_q <= best_idx[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Result register toward the response channel.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_value_q  <= res_q;
			out_status_q <= cmd.res_status;
			out_count_q  <= COUNT_W'(cnt_q);
		end
	end

	assign rsp_value  = out_value_q;
	assign rsp_status = out_status_q;
	assign rsp_count  = out_count_q;

	`BMHQ_ASSERT_IMPLIES(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY))
	`BMHQ_ASSERT_IMPLIES(a_ins_not_full, clk, arst_n, cmd.op == DP_INS_INIT, !sts.full)
	`BMHQ_ASSERT_IMPLIES(a_rm_not_empty, clk, arst_n,
		cmd.op == DP_EX_RD || cmd.op == DP_DEL_RD || cmd.op == DP_DEL_DROP, !sts.empty)

endmodule

### hw/rtl/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// Heap queue controller
// Sequences decode, sift-up and sift-down steps and the result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_max_heap_queue_top_assert.svh"

module bmhq_ctrl
	import bmhq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_EX_LD,
		S_INC_CHK,
		S_DEL_LD,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_FINISH
	} state_t;

	state_t  state_q;
	state_t  state_d;
	logic    fallback_q;
	logic    fallback_d;
	status_e st_q;
	status_e st_d;
	logic    out_valid_q;
	logic    out_valid_d;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	// Next state and the datapath operation for this cycle.
	always_comb begin
		state_d        = state_q;
		fallback_d     = fallback_q;
		st_d           = st_q;
		cmd.op         = DP_NOP;
		cmd.res_load   = 1'b0;
		cmd.res_status = st_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op     = DP_LOAD;
					st_d       = ST_OK;
					fallback_d = 1'b0;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.cmd)
					CMD_INSERT: begin
						if (sts.full) begin
							st_d    = ST_FULL;
							state_d = S_FINISH;
						end else begin
							cmd.op  = DP_INS_INIT;
							state_d = S_UP_RD;
						end
					end
					CMD_EXTRACT: begin
						if (sts.empty) begin
							st_d    = ST_EMPTY;
							state_d = S_FINISH;
						end else begin
							cmd.op  = DP_EX_RD;
							state_d = S_EX_LD;
						end
					end
					CMD_INCREASE: begin
						if (sts.idx_bad) begin
							st_d    = ST_BAD_INDEX;
							state_d = S_FINISH;
						end else begin
							cmd.op  = DP_INC_RD;
							state_d = S_INC_CHK;
						end
					end
					CMD_DELETE: begin
						if (sts.idx_bad) begin
							st_d    = ST_BAD_INDEX;
							state_d = S_FINISH;
						end else if (sts.idx_last) begin
							// Deleting the last position just drops it.
							cmd.op  = DP_DEL_DROP;
							state_d = S_FINISH;
						end else begin
							cmd.op  = DP_DEL_RD;
							state_d = S_DEL_LD;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_EX_LD: begin
				cmd.op  = DP_EX_LD;
				state_d = S_DN_RD;
			end
			S_INC_CHK: begin
				if (sts.not_larger) begin
					st_d    = ST_NOT_LARGER;
					state_d = S_FINISH;
				end else begin
					cmd.op  = DP_INC_INIT;
					state_d = S_UP_RD;
				end
			end
			S_DEL_LD: begin
				// The moved key tries upward first and falls back to a sift down.
				cmd.op     = DP_DEL_LD;
				fallback_d = 1'b1;
				state_d    = S_UP_RD;
			end
			S_UP_RD: begin
				if (sts.pos_root) begin
					if (fallback_q) begin
						fallback_d = 1'b0;
						state_d    = S_DN_RD;
					end else begin
						cmd.op  = DP_UP_PLACE;
						state_d = S_FINISH;
					end
				end else begin
					cmd.op  = DP_UP_RD;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (sts.up_swap) begin
					cmd.op     = DP_UP_MOVE;
					fallback_d = 1'b0;
					state_d    = S_UP_RD;
				end else if (fallback_q) begin
					fallback_d = 1'b0;
					state_d    = S_DN_RD;
				end else begin
					cmd.op  = DP_UP_PLACE;
					state_d = S_FINISH;
				end
			end
			S_DN_RD: begin
				cmd.op  = DP_DN_RD;
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (sts.dn_move) begin
					cmd.op  = DP_DN_MOVE;
					state_d = S_DN_RD;
				end else begin
					cmd.op  = DP_DN_PLACE;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// Hand the result over once the output register is free.
				if (!out_valid_q || rsp_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.res_load) begin
			out_valid_d = 1'b1;
		end else if (rsp_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	// State and registered control outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fallback_q  <= 1'b0;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fallback_q  <= fallback_d;
			st_q        <= st_d;
			out_valid_q <= out_valid_d;
		end
	end

	`BMHQ_ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, cmd.res_load, !out_valid_q || rsp_ready)
	`BMHQ_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.res_load, out_valid_q)
	`BMHQ_ASSERT_IMPLIES(a_fallback_delete, clk, arst_n, fallback_q, sts.cmd == CMD_DELETE)

endmodule

### hw/rtl/binary_max_heap_queue_top.sv
// ----------------------------------------------------------------------------
// Binary max-heap priority queue
// Signed 32-bit keys in a heap store with insert, extract-max, increase-key
// and delete-at-index commands, one result per command.
//
//   Channel  Role  Fields
//   req      sink  command[1:0], value[31:0] signed, index[5:0]
//   rsp      src   result_value[31:0] signed, status[2:0], count[6:0]
//
// One command is processed at a time. A command refused at decode goes straight to the
// result register; an increase that is not larger reads the key, then compares it;
// a heap command walks the levels, each taking a registered store read, then a compare
// and write back. The controller is idle again once the result is registered, so the
// next req transfer can follow even while rsp is stalled; a finished result waits, with
// req held off, until rsp frees up.
// Reset clears the entry count; the store itself is never cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_max_heap_queue_top
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input logic        clk,
	input logic        arst_n,
	bmhq_req_if.sink   req,
	bmhq_rsp_if.source rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer.
	bmhq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Heap store and arithmetic.
	bmhq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_command (req.command),
		.req_value   (req.value),
		.req_index   (req.index),
		.cmd         (cmd),
		.sts         (sts),
		.rsp_value   (rsp.result_value),
		.rsp_status  (rsp.status),
		.rsp_count   (rsp.count)
	);

endmodule
